@@ sv/wsps_pkg.sv @@
// Package for the weekly schedule pump switch: widths, register codes,
// interval and configuration types. Used by the input and configuration interfaces and all modules.
`default_nettype none

package wsps_pkg;

    localparam int NUM_INTERVALS = 4;

    localparam int MINUTE_W = 11;
    localparam int MASK_W   = 7;
    localparam int LEVEL_W  = 12;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int DAY_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 29;

    localparam int unsigned MINUTES_PER_HOUR = 60;
    localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 12'd1000;

    localparam logic MODE_CHECK  = 1'b0;
    localparam logic MODE_TOGGLE = 1'b1;

    localparam logic BASE_SCHEDULED = 1'b0;
    localparam logic BASE_AUTOMATIC = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INTERVAL_ZERO,
        REG_INTERVAL_ONE,
        REG_INTERVAL_TWO,
        REG_INTERVAL_THREE,
        REG_BASE_MODE,
        REG_SCHED_ENABLE,
        REG_LEVEL_THRESHOLD
    } t_reg_idx;

    typedef struct packed {
        logic [MASK_W-1:0]   mask;
        logic [MINUTE_W-1:0] stop;
        logic [MINUTE_W-1:0] start;
    } t_interval;

    typedef struct packed {
        t_interval [NUM_INTERVALS-1:0] intervals;
        logic                          base_mode;
        logic                          sched_enable;
        logic [LEVEL_W-1:0]            threshold;
    } t_cfg;

    typedef struct packed {
        logic               mode;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [DAY_W-1:0]   weekday;
        logic [LEVEL_W-1:0] water_level;
    } t_in_item;

    typedef struct packed {
        logic relay_on;
        logic in_window;
        logic manual_override;
    } t_out_item;

endpackage

`default_nettype wire

@@ sv/wsps_if.sv @@
// Channel interfaces of the weekly schedule pump switch: check items in,
// relay results out, and the configuration write channel. Uses wsps_pkg.
`default_nettype none

interface wsps_in_if import wsps_pkg::*;;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [DAY_W-1:0]   weekday;
    logic [LEVEL_W-1:0] water_level;

    modport source(output valid, mode, hour, minute, weekday, water_level, input ready);
    modport sink(input valid, mode, hour, minute, weekday, water_level, output ready);
endinterface

interface wsps_out_if;
    logic valid;
    logic ready;
    logic relay_on;
    logic in_window;
    logic manual_override;

    modport source(output valid, relay_on, in_window, manual_override, input ready);
    modport sink(input valid, relay_on, in_window, manual_override, output ready);
endinterface

interface wsps_cfg_if import wsps_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/wsps_cfg.sv @@
// Configuration register file of the weekly schedule pump switch.
// Depends on wsps_pkg and the wsps_cfg_if interface.
`default_nettype none

module wsps_cfg import wsps_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    wsps_cfg_if.sink    i_cfg,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.intervals    <= '0;
            r_cfg.base_mode    <= BASE_SCHEDULED;
            r_cfg.sched_enable <= 1'b1;
            r_cfg.threshold    <= THRESHOLD_RESET;
        end else if (i_cfg.valid) begin
            for (int k = 0; k < NUM_INTERVALS; k++) begin
                if (i_cfg.index == CFG_IDX_W'(k)) begin
                    r_cfg.intervals[k] <= t_interval'(i_cfg.data);
                end
            end
            case (t_reg_idx'(i_cfg.index))
                REG_BASE_MODE: begin
                    r_cfg.base_mode <= i_cfg.data[0];
                end
                REG_SCHED_ENABLE: begin
                    r_cfg.sched_enable <= i_cfg.data[0];
                end
                REG_LEVEL_THRESHOLD: begin
                    r_cfg.threshold <= i_cfg.data[LEVEL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sv/wsps_match.sv @@
// Time window matcher: compares the minute of day against every interval
// in parallel and checks the weekday mask. Depends on wsps_pkg.
`default_nettype none

module wsps_match import wsps_pkg::*; (
    input  wire logic [HOUR_W-1:0]         i_hour,
    input  wire logic [MIN_W-1:0]          i_minute,
    input  wire logic [DAY_W-1:0]          i_weekday,
    input  wire t_interval [NUM_INTERVALS-1:0] i_intervals,
    output logic                           o_window
);

    logic [MINUTE_W-1:0]    now_min;
    logic [NUM_INTERVALS-1:0] hit;

    assign now_min = MINUTE_W'(MINUTE_W'(i_hour) * MINUTE_W'(MINUTES_PER_HOUR))
                   + MINUTE_W'(i_minute);

    always_comb begin
        for (int k = 0; k < NUM_INTERVALS; k++) begin
            logic [MASK_W:0] day_bits;
            day_bits = {1'b0, i_intervals[k].mask};
            hit[k] = (i_intervals[k].start <= now_min) && (now_min <= i_intervals[k].stop)
                   && day_bits[i_weekday];
        end
    end

    assign o_window = |hit;

endmodule

`default_nettype wire

@@ sv/weekly_schedule_pump_switch.sv @@
// Weekly schedule pump switch: an input transfer is registered in stage one,
// and stage one moves into the output register once that is empty or its result is taken.
// One item is accepted every cycle while the result side keeps taking transfers.
// Synchronous active-low reset clears both valid flags, relay and override state,
// and loads the configuration reset values. Depends on wsps_pkg, wsps_if,
// wsps_cfg and wsps_match.
`default_nettype none

module weekly_schedule_pump_switch import wsps_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    wsps_in_if.sink   i_in,
    wsps_out_if.source o_out,
    wsps_cfg_if.sink  i_cfg
);

    t_cfg      cfg;
    logic      r_s1_valid;
    t_in_item  r_s1;
    logic      r_out_valid;
    t_out_item r_out;
    logic      r_relay;
    logic      r_manual;

    logic      s1_go;
    logic      window;
    logic      n_relay;
    logic      n_manual;
    logic      n_window;

    wsps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    wsps_match u_match (
        .i_hour      (r_s1.hour),
        .i_minute    (r_s1.minute),
        .i_weekday   (r_s1.weekday),
        .i_intervals (cfg.intervals),
        .o_window    (window)
    );

    assign s1_go      = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_go;

    always_comb begin
        n_relay  = r_relay;
        n_manual = r_manual;
        n_window = 1'b0;
        if (r_s1.mode == MODE_TOGGLE) begin
            n_manual = !r_manual;
            n_relay  = !r_manual;
        end else begin
            n_window = window;
            if (!r_manual) begin
                n_relay = cfg.sched_enable && window
                       && (cfg.base_mode == BASE_SCHEDULED
                           || r_s1.water_level > cfg.threshold);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_relay     <= 1'b0;
            r_manual    <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
                r_relay     <= n_relay;
                r_manual    <= n_manual;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1.mode        <= i_in.mode;
            r_s1.hour        <= i_in.hour;
            r_s1.minute      <= i_in.minute;
            r_s1.weekday     <= i_in.weekday;
            r_s1.water_level <= i_in.water_level;
        end
        if (s1_go) begin
            r_out.relay_on        <= n_relay;
            r_out.in_window       <= n_window;
            r_out.manual_override <= n_manual;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.relay_on        = r_out.relay_on;
    assign o_out.in_window       = r_out.in_window;
    assign o_out.manual_override = r_out.manual_override;

endmodule

`default_nettype wire
